[rtl/lph_pkg.sv]
`timescale 1ns / 1ps

package lph_pkg;

  // Width of a stored key.
  localparam int unsigned KeyW = 31;
  // Width of the slot index in a result.
  localparam int unsigned SlotIdxW = 4;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_REDUCE,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [SlotIdxW-1:0] slot_index;
    logic [1:0]          status;
  } out_t;

endpackage

[rtl/linear_probe_hash_table_unit.sv]
`timescale 1ns / 1ps
// Insert and search hash the key to its home slot, then probe up to TABLE_SIZE slots in
// turn; clear sweeps every slot, and the unused op code goes straight to the result.
// A stalled result beat holds the block in its last step.
// Throughput: one item at a time; the home slot comes from a reciprocal multiply,
// then a multiply and subtract, and the probe walk reads one slot per cycle.
// Reset: control state clears at once, then a sweep over the slots marks every
// slot empty; no input beat is accepted during that sweep.
module linear_probe_hash_table_unit
  import lph_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 13
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Slot index width; also wide enough for the probe counter, which counts 0..TABLE_SIZE-1.
  localparam int unsigned IdxW     = $clog2(TABLE_SIZE);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(TABLE_SIZE - 1);

  // The home slot is the key modulo TABLE_SIZE. The quotient comes from a multiply by
  // the rounded-up reciprocal 2^RecipS / TABLE_SIZE, which is exact for every key of
  // KeyW bits and fits in 32 bits; the remainder is the key minus quotient times size.
  localparam int unsigned RecipS    = KeyW + $clog2(TABLE_SIZE);
  localparam logic [63:0] RecipWide =
    ((64'd1 << RecipS) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [31:0] RecipM    = RecipWide[31:0];
  localparam logic [KeyW:0] SizeK   = (KeyW + 1)'(TABLE_SIZE);

  // Each memory word holds an occupied flag on top of the stored key.
  localparam int unsigned WordW = KeyW + 1;

  state_e              state_q, state_d;
  logic [KeyW-1:0]     quot_q, quot_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [1:0]          op_q, op_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic [IdxW-1:0]     probes_q, probes_d;
  logic                clr_reply_q, clr_reply_d;
  out_t                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  // Slot memory: one write port, one read port, registered read data.
  logic [WordW-1:0]    mem [TABLE_SIZE];
  logic [WordW-1:0]    rd_q;
  logic                we;
  logic [IdxW-1:0]     wr_addr;
  logic [WordW-1:0]    wr_data;
  logic [IdxW-1:0]     rd_addr;

  logic                rd_occ;
  logic                rd_match;
  logic                last_probe;
  logic [IdxW-1:0]     next_slot;
  logic                can_out;
  logic                in_fire;
  logic [63:0]         quot_prod;
  logic [KeyW:0]       quot_mul;
  logic [KeyW:0]       key_rem;
  logic [IdxW+SlotIdxW-1:0] slot_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The result register can take a new beat when it is empty or is being drained.
  assign can_out    = !out_valid_q || out_ready_i;

  assign rd_occ     = rd_q[WordW-1];
  assign rd_match   = (rd_q[KeyW-1:0] == key_q);
  assign last_probe = (probes_q == LastSlot);
  assign next_slot  = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign slot_ext   = {{SlotIdxW{1'b0}}, slot_q};

  // First hash cycle: the product whose upper bits are the quotient.
  assign quot_prod  = 64'(key_q) * 64'(RecipM);
  // Second hash cycle: the remainder, which is always below TABLE_SIZE.
  assign quot_mul   = {1'b0, quot_q} * SizeK;
  assign key_rem    = {1'b0, key_q} - quot_mul;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (slot_q == LastSlot) begin
          state_d = clr_reply_q ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.op)
            OP_CLEAR:  state_d = S_CLEAR;
            OP_INSERT,
            OP_SEARCH: state_d = S_HASH;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_HASH: state_d = S_REDUCE;
      S_REDUCE: state_d = S_READ;
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (!rd_occ || (op_q == OP_SEARCH && rd_match) || last_probe) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (can_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory control and result.
  always_comb begin
    quot_d      = quot_q;
    key_d       = key_q;
    op_d        = op_q;
    slot_d      = slot_q;
    probes_d    = probes_q;
    clr_reply_d = clr_reply_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    wr_addr     = slot_q;
    wr_data     = '0;
    rd_addr     = slot_q;

    case (state_q)
      S_CLEAR: begin
        // Mark one slot empty per cycle; the stored key does not matter.
        we     = 1'b1;
        slot_d = next_slot;
      end
      S_IDLE: begin
        if (in_fire) begin
          op_d        = in_data_i.op;
          key_d       = in_data_i.key;
          slot_d      = '0;
          probes_d    = '0;
          clr_reply_d = 1'b1;
          res_d.slot_index = '0;
          res_d.status     = ST_OK;
        end
      end
      S_HASH: begin
        quot_d = KeyW'(quot_prod >> RecipS);
      end
      S_REDUCE: begin
        slot_d = key_rem[IdxW-1:0];
      end
      S_READ: begin
        rd_addr = slot_q;
      end
      S_CHECK: begin
        if (op_q == OP_INSERT) begin
          if (!rd_occ) begin
            we               = 1'b1;
            wr_data          = {1'b1, key_q};
            res_d.slot_index = slot_ext[SlotIdxW-1:0];
            res_d.status     = ST_OK;
          end else if (last_probe) begin
            res_d.status = ST_FULL;
          end
        end else begin
          if (!rd_occ) begin
            res_d.status = ST_MISS;
          end else if (rd_match) begin
            res_d.slot_index = slot_ext[SlotIdxW-1:0];
            res_d.status     = ST_OK;
          end else if (last_probe) begin
            res_d.status = ST_MISS;
          end
        end
        // Probe on: read the following slot so its word is ready next cycle.
        rd_addr  = next_slot;
        slot_d   = next_slot;
        probes_d = probes_q + 1'b1;
      end
      S_FINISH: begin
        if (can_out) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      slot_q      <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      clr_reply_q <= clr_reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    quot_q   <= quot_d;
    key_q    <= key_d;
    op_q     <= op_d;
    probes_q <= probes_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule
